// File: sv/usf_pkg.sv
package usf_pkg;

  localparam int CLIENT_SLOTS = 64;
  localparam int SLOT_BITS    = $clog2(CLIENT_SLOTS);
  localparam int CNT_BITS     = 32;
  localparam int CMD_BITS     = 2;
  localparam int STATUS_BITS  = 3;
  localparam int DATA_BYTES   = (SLOT_BITS + CNT_BITS + 7) / 8;
  localparam int DATA_BITS    = DATA_BYTES * 8;
  localparam int PAD_BITS     = DATA_BITS - SLOT_BITS - CNT_BITS;

  localparam logic [CNT_BITS-1:0] RESET_COUNT = CNT_BITS'(1);

  typedef logic [CNT_BITS-1:0]  cnt_t;
  typedef logic [SLOT_BITS-1:0] slot_t;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_SEND  = 2'd0,
    CMD_RECV  = 2'd1,
    CMD_RESET = 2'd2
  } cmd_t;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_TAG         = 3'd0,
    ST_ACCEPT      = 3'd1,
    ST_ACCEPT_WRAP = 3'd2,
    ST_STALE       = 3'd3,
    ST_CONN        = 3'd4,
    ST_RESET_DONE  = 3'd5
  } status_t;

endpackage

// File: sv/udp_sequence_filter_unit.sv
// A request is taken into the table read registers, resolved in S_CALC and registered onto out_*;
// S_CALC holds while out_* is full, and a new request is taken only back in S_IDLE.
// A request with an unused command gives no result and frees the block in the next cycle.
// Reset (rst_n low, synchronous): initial_count returns to 1, all counters read as 1 through
// per-slot valid bits cleared at once; no clearing pass, requests are taken right after reset.
module udp_sequence_filter_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [usf_pkg::DATA_BITS-1:0]     in_tdata,   // client_id, seq_number, zero pad
  input  logic [usf_pkg::CMD_BITS-1:0]      in_tuser,   // command
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [usf_pkg::DATA_BITS-1:0]     out_tdata,  // client_out, tag_value, zero pad
  output logic [usf_pkg::STATUS_BITS-1:0]   out_tuser,  // status
  input  logic                              cfg_wr_en,
  input  logic [usf_pkg::CNT_BITS-1:0]      cfg_wr_data
);

  typedef enum logic {
    S_IDLE,
    S_CALC
  } state_t;

  state_t                          state_r;
  usf_pkg::cmd_t                   cmd_r;
  usf_pkg::slot_t                  slot_r;
  usf_pkg::cnt_t                   seq_r;
  usf_pkg::cnt_t                   init_r;

  usf_pkg::cnt_t                   send_mem [usf_pkg::CLIENT_SLOTS];
  usf_pkg::cnt_t                   recv_mem [usf_pkg::CLIENT_SLOTS];
  usf_pkg::cnt_t                   send_rd_r;
  usf_pkg::cnt_t                   recv_rd_r;
  logic [usf_pkg::CLIENT_SLOTS-1:0] send_vld_r;
  logic [usf_pkg::CLIENT_SLOTS-1:0] recv_vld_r;
  logic                            send_hit_r;
  logic                            recv_hit_r;

  logic                            out_valid_r;
  usf_pkg::slot_t                  out_client_r;
  usf_pkg::cnt_t                   out_tag_r;
  usf_pkg::status_t                out_status_r;

  logic                            in_fire;
  usf_pkg::slot_t                  in_slot;
  usf_pkg::cnt_t                   send_cur;
  usf_pkg::cnt_t                   recv_cur;
  logic                            send_we;
  logic                            recv_we;
  usf_pkg::cnt_t                   send_wd;
  usf_pkg::cnt_t                   recv_wd;
  usf_pkg::status_t                status;
  usf_pkg::cnt_t                   tag;
  logic                            has_result;
  logic                            calc_go;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign in_slot   = in_tdata[usf_pkg::SLOT_BITS-1:0];

  // Read both tables at accept time; data is ready in S_CALC.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      send_rd_r  <= send_mem[in_slot];
      recv_rd_r  <= recv_mem[in_slot];
      send_hit_r <= send_vld_r[in_slot];
      recv_hit_r <= recv_vld_r[in_slot];
      cmd_r      <= usf_pkg::cmd_t'(in_tuser);
      slot_r     <= in_slot;
      seq_r      <= in_tdata[usf_pkg::SLOT_BITS +: usf_pkg::CNT_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (send_we) begin
      send_mem[slot_r] <= send_wd;
    end
    if (recv_we) begin
      recv_mem[slot_r] <= recv_wd;
    end
  end

  // Untouched slots read as the reset count.
  assign send_cur = send_hit_r ? send_rd_r : usf_pkg::RESET_COUNT;
  assign recv_cur = recv_hit_r ? recv_rd_r : usf_pkg::RESET_COUNT;

  always_comb begin
    logic upd_send;
    logic upd_recv;
    upd_send   = 1'b0;
    upd_recv   = 1'b0;
    send_wd    = send_cur + usf_pkg::CNT_BITS'(1);
    recv_wd    = seq_r;
    status     = usf_pkg::ST_STALE;
    tag        = '0;
    has_result = 1'b1;
    unique case (cmd_r)
      usf_pkg::CMD_SEND: begin
        upd_send = 1'b1;
        tag      = send_cur;
        status   = usf_pkg::ST_TAG;
      end
      usf_pkg::CMD_RECV: begin
        if (seq_r == '0) begin
          status = usf_pkg::ST_CONN;
        end else if (seq_r >= recv_cur) begin
          upd_recv = 1'b1;
          status   = usf_pkg::ST_ACCEPT;
        end else if ((recv_cur - seq_r) > (recv_cur >> 1)) begin
          // Wraparound: reload, then check once more.
          upd_recv = 1'b1;
          if (seq_r >= init_r) begin
            status = usf_pkg::ST_ACCEPT_WRAP;
          end else begin
            recv_wd = init_r;
            status  = usf_pkg::ST_STALE;
          end
        end else begin
          status = usf_pkg::ST_STALE;
        end
      end
      usf_pkg::CMD_RESET: begin
        upd_send = 1'b1;
        upd_recv = 1'b1;
        send_wd  = init_r;
        recv_wd  = init_r;
        status   = usf_pkg::ST_RESET_DONE;
      end
      default: begin
        has_result = 1'b0;
      end
    endcase
    calc_go = (state_r == S_CALC) && (!has_result || !out_valid_r || out_tready);
    send_we = calc_go && upd_send;
    recv_we = calc_go && upd_recv;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      init_r      <= usf_pkg::RESET_COUNT;
      send_vld_r  <= '0;
      recv_vld_r  <= '0;
    end else begin
      if (cfg_wr_en) begin
        init_r <= cfg_wr_data;
      end
      if (send_we) begin
        send_vld_r[slot_r] <= 1'b1;
      end
      if (recv_we) begin
        recv_vld_r[slot_r] <= 1'b1;
      end
      if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            state_r <= S_CALC;
          end
        end
        S_CALC: begin
          // Hold until the output register is free.
          if (calc_go) begin
            state_r <= S_IDLE;
            if (has_result) begin
              out_valid_r <= 1'b1;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (calc_go && has_result) begin
      out_client_r <= slot_r;
      out_tag_r    <= tag;
      out_status_r <= status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{usf_pkg::PAD_BITS{1'b0}}, out_tag_r, out_client_r};
  assign out_tuser  = out_status_r;

endmodule

// File: test/udp_sequence_filter_unit_tb.sv
module udp_sequence_filter_unit_tb;

  localparam logic [usf_pkg::CMD_BITS-1:0] CMD_UNUSED = 2'd3;
  localparam int HOLD_OFF_CYCLES = 400;

  typedef struct packed {
    logic [usf_pkg::CMD_BITS-1:0] cmd;
    usf_pkg::slot_t               client;
    usf_pkg::cnt_t                seq;
  } request_t;

  typedef struct packed {
    usf_pkg::slot_t   client;
    usf_pkg::status_t status;
    usf_pkg::cnt_t    tag;
  } result_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [usf_pkg::DATA_BITS-1:0]   in_tdata = '0;
  logic [usf_pkg::CMD_BITS-1:0]    in_tuser = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [usf_pkg::DATA_BITS-1:0]   out_tdata;
  logic [usf_pkg::STATUS_BITS-1:0] out_tuser;
  logic                            cfg_wr_en = 1'b0;
  logic [usf_pkg::CNT_BITS-1:0]    cfg_wr_data = '0;

  // counter tables as the block should hold them
  usf_pkg::cnt_t init_count = usf_pkg::RESET_COUNT;
  usf_pkg::cnt_t send_cnt[usf_pkg::CLIENT_SLOTS] = '{default: usf_pkg::RESET_COUNT};
  usf_pkg::cnt_t recv_cnt[usf_pkg::CLIENT_SLOTS] = '{default: usf_pkg::RESET_COUNT};
  // per-slot sequence source used to build well-formed receive streams
  usf_pkg::cnt_t stream_seq[usf_pkg::CLIENT_SLOTS] = '{default: usf_pkg::RESET_COUNT};

  request_t request_queue[$];
  result_t  pending_results[$];
  request_t cur_req;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;
  int error_count = 0;
  int request_count = 0;
  int result_count = 0;
  int status_seen[8] = '{default: 0};

  udp_sequence_filter_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #1 clk = ~clk;

  task automatic track_request(input request_t r);
    result_t       res;
    usf_pkg::cnt_t cur;
    res.client = r.client;
    res.tag    = '0;
    res.status = usf_pkg::ST_TAG;
    case (r.cmd)
      usf_pkg::CMD_SEND: begin
        res.tag = send_cnt[r.client];
        send_cnt[r.client] = send_cnt[r.client] + 1'b1;
      end
      usf_pkg::CMD_RECV: begin
        cur = recv_cnt[r.client];
        if (r.seq == '0) begin
          res.status = usf_pkg::ST_CONN;
        end else if (r.seq >= cur) begin
          recv_cnt[r.client] = r.seq;
          res.status = usf_pkg::ST_ACCEPT;
        end else if ((cur - r.seq) > (cur >> 1)) begin
          // far below: treat as wraparound, reload and check once more
          if (r.seq >= init_count) begin
            recv_cnt[r.client] = r.seq;
            res.status = usf_pkg::ST_ACCEPT_WRAP;
          end else begin
            recv_cnt[r.client] = init_count;
            res.status = usf_pkg::ST_STALE;
          end
        end else begin
          res.status = usf_pkg::ST_STALE;
        end
      end
      usf_pkg::CMD_RESET: begin
        send_cnt[r.client] = init_count;
        recv_cnt[r.client] = init_count;
        res.status = usf_pkg::ST_RESET_DONE;
      end
      default: return;
    endcase
    pending_results.push_back(res);
  endtask

  task automatic note_error(input string msg);
    if (error_count < 10)
      $display("ERROR at %0t: %s", $time, msg);
    error_count++;
  endtask

  // driver: present the next request once the current one is taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        track_request(cur_req);
        request_count++;
      end
      if (!in_tvalid || in_tready) begin
        if (request_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          cur_req = request_queue.pop_front();
          in_tvalid <= 1'b1;
          in_tuser <= cur_req.cmd;
          in_tdata <= {{usf_pkg::PAD_BITS{1'b0}}, cur_req.seq, cur_req.client};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.client = out_tdata[usf_pkg::SLOT_BITS-1:0];
      got.tag    = out_tdata[usf_pkg::SLOT_BITS+usf_pkg::CNT_BITS-1:usf_pkg::SLOT_BITS];
      got.status = usf_pkg::status_t'(out_tuser);
      result_count++;
      status_seen[out_tuser]++;
      if (pending_results.size() == 0) begin
        note_error($sformatf("result with no request pending: client %0d status %0d tag %h",
                             got.client, got.status, got.tag));
      end else begin
        want = pending_results.pop_front();
        if (got !== want)
          note_error($sformatf({"client %0d/%0d status %0d/%0d tag %h/%h ",
                                "(expected/actual)"}, want.client, got.client,
                               want.status, got.status, want.tag, got.tag));
      end
    end
    out_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (hold_left != 0)
      hold_left <= hold_left - 1;
  end

  task automatic push(input logic [usf_pkg::CMD_BITS-1:0] cmd, input int client,
                      input usf_pkg::cnt_t seq);
    request_t r;
    r.cmd    = cmd;
    r.client = usf_pkg::slot_t'(client);
    r.seq    = seq;
    request_queue.push_back(r);
  endtask

  task automatic push_random(input int count);
    int            pick;
    int            k;
    int            c;
    usf_pkg::cnt_t seq;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      c = ($urandom_range(0, 99) < 70) ? $urandom_range(0, 7) : $urandom_range(0, 63);
      if (pick < 25) begin
        push(usf_pkg::CMD_SEND, c, $urandom);
      end else if (pick < 85) begin
        k = $urandom_range(0, 99);
        if (k < 55) begin
          stream_seq[c] = stream_seq[c] + $urandom_range(1, 1000);
          seq = stream_seq[c];
        end else if (k < 70) begin
          seq = stream_seq[c] - $urandom_range(1, 64);
        end else if (k < 75) begin
          seq = '0;
        end else if (k < 88) begin
          seq = $urandom;
        end else begin
          // jump near the top so the stream wraps soon
          stream_seq[c] = 32'hFFFF_FFFF - $urandom_range(0, 3000);
          seq = stream_seq[c];
        end
        push(usf_pkg::CMD_RECV, c, seq);
      end else if (pick < 95) begin
        push(usf_pkg::CMD_RESET, c, $urandom);
      end else begin
        push(CMD_UNUSED, c, $urandom);
      end
    end
  endtask

  task automatic wait_idle();
    while (request_queue.size() != 0 || in_tvalid || pending_results.size() != 0)
      @(negedge clk);
    // an unused command may still occupy the block after the queues drain
    repeat (4) @(negedge clk);
  endtask

  task automatic write_initial(input usf_pkg::cnt_t value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    init_count = value;
    @(negedge clk);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset value of initial_count, no idling
    push(usf_pkg::CMD_SEND, 0, '0);
    push(usf_pkg::CMD_SEND, 63, 32'hFFFF_FFFF);
    push(usf_pkg::CMD_RECV, 0, '0);
    push(usf_pkg::CMD_RECV, 1, 32'hFFFF_FFFF);
    push(usf_pkg::CMD_RECV, 1, 32'd5);
    push(usf_pkg::CMD_RECV, 1, 32'd3);
    push(usf_pkg::CMD_RECV, 2, 32'd1);
    push(usf_pkg::CMD_RESET, 1, '0);
    push(usf_pkg::CMD_SEND, 1, '0);
    push(CMD_UNUSED, 7, 32'hFFFF_FFFF);
    push(usf_pkg::CMD_SEND, 0, '0);
    push_random(300);
    wait_idle();

    // largest initial_count, sender idles
    write_initial(32'hFFFF_FFFF);
    send_idle_pct = 79;
    push(usf_pkg::CMD_RESET, 5, '0);
    push(usf_pkg::CMD_SEND, 5, '0);
    push(usf_pkg::CMD_SEND, 5, '0);
    push(usf_pkg::CMD_RECV, 5, 32'h7FFF_FFFF);
    push_random(300);
    wait_idle();

    // zero initial_count, receiver stalls, then a long hold-off
    write_initial('0);
    send_idle_pct = 0;
    recv_stall_pct = 79;
    push(usf_pkg::CMD_RESET, 9, '0);
    push(usf_pkg::CMD_SEND, 9, '0);
    push(usf_pkg::CMD_RECV, 9, 32'd1000);
    push(usf_pkg::CMD_RECV, 9, 32'd10);
    push_random(300);
    hold_left = HOLD_OFF_CYCLES;
    wait_idle();

    // midrange initial_count, light idling on both sides
    write_initial(32'h8000_0000);
    send_idle_pct = 7;
    recv_stall_pct = 7;
    push(usf_pkg::CMD_RESET, 12, '0);
    push(usf_pkg::CMD_RECV, 12, 32'hF000_0000);
    push(usf_pkg::CMD_RECV, 12, 32'h10);
    push_random(300);
    wait_idle();

    write_initial($urandom);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    push_random(100);
    wait_idle();
    repeat (10) @(posedge clk);

    $display("covered %0d requests, %0d results over five initial counts and four idle mixes",
             request_count, result_count);
    $display("statuses: %0d tag, %0d accept, %0d wrap, %0d stale, %0d connect, %0d reset",
             status_seen[usf_pkg::ST_TAG], status_seen[usf_pkg::ST_ACCEPT],
             status_seen[usf_pkg::ST_ACCEPT_WRAP], status_seen[usf_pkg::ST_STALE],
             status_seen[usf_pkg::ST_CONN], status_seen[usf_pkg::ST_RESET_DONE]);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d errors", error_count);
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("status: fail");
    $finish;
  end

endmodule
